>>> hw/rtl/itoaf_pkg.sv
// Shared types and constants for the integer to ASCII formatter.
// Used by itoaf_ctrl, itoaf_dp and integer_to_ascii_formatter_unit.
package itoaf_pkg;

    localparam int ITOAF_MAX_WIDTH = 32;

    // digit store: up to 32 binary digits
    localparam int DIG_MAX = 32;
    localparam int DIG_IW  = $clog2(DIG_MAX);
    // character counters: hold up to 127
    localparam int CNT_W   = 7;

    localparam logic [1:0] RADIX_BIN = 2'd0;
    localparam logic [1:0] RADIX_OCT = 2'd1;
    localparam logic [1:0] RADIX_DEC = 2'd2;
    localparam logic [1:0] RADIX_HEX = 2'd3;

    localparam logic [7:0] CHAR_MINUS   = 8'h2D;
    localparam logic [7:0] CHAR_SPACE   = 8'h20;
    localparam logic [7:0] CHAR_ZERO    = 8'h30;
    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_LOWER_A = 8'h61;

    // ceil(2^35 / 10): floor(x * RECIP10 / 2^35) == x / 10 for any 32-bit x
    localparam logic [31:0] RECIP10     = 32'hCCCC_CCCD;
    localparam int          RECIP_SHIFT = 35;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_DIGIT,
        S_SETUP,
        S_LEAD,
        S_PADL,
        S_TEXT,
        S_PADR
    } t_state;

    typedef enum logic [1:0] {
        SEL_MINUS,
        SEL_PAD,
        SEL_TEXT
    } t_char_sel;

    typedef struct packed {
        logic      load;
        logic      div;
        logic      digit;
        logic      setup;
        logic      emit;
        t_char_sel sel;
        logic      last;
    } t_cmd;

    typedef struct packed {
        logic is_dec;
        logic quot_zero;
        logic lead;
        logic pad_pre;
        logic pad_post;
        logic pad_one;
        logic text_one;
    } t_status;

endpackage

>>> hw/rtl/itoaf_ctrl.sv
// Sequencer for the formatter: digit extraction, setup and character emission.
// Depends on itoaf_pkg; drives commands into itoaf_dp and reads its status.
module itoaf_ctrl import itoaf_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    start,
    output logic    busy,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign busy = (r_state != S_IDLE);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_state = i_status.is_dec ? S_DIV : S_DIGIT;
                end
            end
            S_DIV: begin
                n_state = S_DIGIT;
            end
            S_DIGIT: begin
                if (i_status.quot_zero) begin
                    n_state = S_SETUP;
                end else begin
                    n_state = i_status.is_dec ? S_DIV : S_DIGIT;
                end
            end
            S_SETUP: begin
                n_state = S_LEAD;
            end
            S_LEAD: begin
                n_state = i_status.pad_pre ? S_PADL : S_TEXT;
            end
            S_PADL: begin
                if (i_status.pad_one) begin
                    n_state = S_TEXT;
                end
            end
            S_TEXT: begin
                if (i_status.text_one) begin
                    n_state = i_status.pad_post ? S_PADR : S_IDLE;
                end
            end
            S_PADR: begin
                if (i_status.pad_one) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd = '0;
        o_cmd.sel = SEL_PAD;
        case (r_state)
            S_IDLE: begin
                o_cmd.load = start;
            end
            S_DIV: begin
                o_cmd.div = 1'b1;
            end
            S_DIGIT: begin
                o_cmd.digit = 1'b1;
            end
            S_SETUP: begin
                o_cmd.setup = 1'b1;
            end
            S_LEAD: begin
                // lead minus only for a zero-padded negative with a width
                o_cmd.emit = i_status.lead;
                o_cmd.sel  = SEL_MINUS;
            end
            S_PADL: begin
                o_cmd.emit = 1'b1;
                o_cmd.sel  = SEL_PAD;
            end
            S_TEXT: begin
                o_cmd.emit = 1'b1;
                o_cmd.sel  = SEL_TEXT;
                o_cmd.last = i_status.text_one && !i_status.pad_post;
            end
            S_PADR: begin
                o_cmd.emit = 1'b1;
                o_cmd.sel  = SEL_PAD;
                o_cmd.last = i_status.pad_one;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

>>> hw/rtl/itoaf_dp.sv
// Datapath for the formatter: operand registers, divide-by-radix step,
// digit store, pad and text counters and the registered character output.
// Depends on itoaf_pkg; commanded by itoaf_ctrl.
module itoaf_dp import itoaf_pkg::*; #(
    parameter int MAX_WIDTH = ITOAF_MAX_WIDTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [31:0] i_value,
    input  logic [1:0]  i_radix_select,
    input  logic        i_is_signed,
    input  logic        i_is_long,
    input  logic [5:0]  i_field_width,
    input  logic        i_left_justify,
    input  logic        i_zero_fill,
    input  logic        i_upper_case,
    input  t_cmd        i_cmd,
    output t_status     o_status,
    output logic        o_char_strobe,
    output logic [7:0]  o_out_char,
    output logic        o_last_char
);

    localparam logic [CNT_W-1:0] MAX_W = CNT_W'(MAX_WIDTH);

    // operands
    logic [31:0]      r_mag;
    logic [31:0]      r_quot;
    logic [1:0]       r_radix;
    logic             r_neg;
    logic [5:0]       r_fw;
    logic             r_left_justify;
    logic             r_zero_fill;
    logic             r_upper;

    // digit store
    logic [3:0]       r_digits [DIG_MAX];
    logic [DIG_IW:0]  r_nd;
    logic [DIG_IW-1:0] r_dptr;

    // emission plan
    logic             r_lead;
    logic             r_minus_pend;
    logic [CNT_W-1:0] r_pad;
    logic [CNT_W-1:0] r_text;

    // output register
    logic             r_strobe;
    logic [7:0]       r_char;
    logic             r_last;

    // load
    logic [31:0] v_m;
    logic [31:0] v_neg;
    logic        v_top;
    logic        v_is_neg;

    always_comb begin
        v_m      = i_is_long ? i_value : {16'h0000, i_value[15:0]};
        v_top    = i_is_long ? i_value[31] : i_value[15];
        v_is_neg = i_is_signed && (i_radix_select == RADIX_DEC) && (v_m != 32'd0) && v_top;
        v_neg    = 32'd0 - v_m;
        if (!i_is_long) begin
            v_neg = {16'h0000, v_neg[15:0]};
        end
    end

    // divide step
    logic [63:0] prod;
    logic [31:0] quot;
    logic [31:0] q10;
    logic [31:0] rem_full;
    logic [3:0]  dig;

    assign prod     = {32'd0, r_mag} * {32'd0, RECIP10};
    assign q10      = {r_quot[28:0], 3'b000} + {r_quot[30:0], 1'b0};
    assign rem_full = r_mag - q10;

    always_comb begin
        case (r_radix)
            RADIX_BIN: begin
                dig  = {3'b000, r_mag[0]};
                quot = {1'b0, r_mag[31:1]};
            end
            RADIX_OCT: begin
                dig  = {1'b0, r_mag[2:0]};
                quot = {3'b000, r_mag[31:3]};
            end
            RADIX_HEX: begin
                dig  = r_mag[3:0];
                quot = {4'h0, r_mag[31:4]};
            end
            default: begin
                dig  = rem_full[3:0];
                quot = r_quot;
            end
        endcase
    end

    // plan
    logic [CNT_W-1:0] fw7;
    logic [CNT_W-1:0] w_sat;
    logic             p_lead;
    logic [CNT_W-1:0] wp;
    logic             p_inline;
    logic [CNT_W-1:0] len;
    logic [CNT_W-1:0] p_text;
    logic [CNT_W-1:0] p_pad;

    always_comb begin
        fw7      = CNT_W'(r_fw);
        w_sat    = (fw7 > MAX_W) ? MAX_W : fw7;
        p_lead   = r_neg && (w_sat != '0) && r_zero_fill;
        wp       = w_sat - CNT_W'(p_lead);
        p_inline = r_neg && !p_lead;
        len      = CNT_W'(r_nd) + CNT_W'(p_inline);
        if (wp == '0) begin
            p_text = len;
            p_pad  = '0;
        end else if (len >= wp) begin
            p_text = wp;
            p_pad  = '0;
        end else begin
            p_text = len;
            p_pad  = wp - len;
        end
    end

    // character selection
    logic [3:0] cur_dig;
    logic [7:0] letter_base;
    logic [7:0] text_char;
    logic [7:0] pad_char;
    logic [7:0] sel_char;

    always_comb begin
        cur_dig     = r_digits[r_dptr];
        letter_base = r_upper ? CHAR_UPPER_A : CHAR_LOWER_A;
        if (r_minus_pend) begin
            text_char = CHAR_MINUS;
        end else if (cur_dig >= 4'd10) begin
            text_char = letter_base + {4'h0, cur_dig - 4'd10};
        end else begin
            text_char = CHAR_ZERO + {4'h0, cur_dig};
        end
        pad_char = r_zero_fill ? CHAR_ZERO : CHAR_SPACE;
        case (i_cmd.sel)
            SEL_MINUS: sel_char = CHAR_MINUS;
            SEL_PAD:   sel_char = pad_char;
            SEL_TEXT:  sel_char = text_char;
            default:   sel_char = pad_char;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mag          <= v_is_neg ? v_neg : v_m;
            r_radix        <= i_radix_select;
            r_neg          <= v_is_neg;
            r_fw           <= i_field_width;
            r_left_justify <= i_left_justify;
            r_zero_fill    <= i_zero_fill;
            r_upper        <= i_upper_case;
            r_nd           <= '0;
        end
        if (i_cmd.div) begin
            r_quot <= {3'b000, prod[63:RECIP_SHIFT]};
        end
        if (i_cmd.digit) begin
            r_digits[r_nd[DIG_IW-1:0]] <= dig;
            r_nd  <= r_nd + 1'b1;
            r_mag <= quot;
        end
        if (i_cmd.setup) begin
            r_lead       <= p_lead;
            r_minus_pend <= p_inline;
            r_pad        <= p_pad;
            r_text       <= p_text;
            r_dptr       <= DIG_IW'(r_nd - 1'b1);
        end
        if (i_cmd.emit) begin
            case (i_cmd.sel)
                SEL_PAD: begin
                    r_pad <= r_pad - 1'b1;
                end
                SEL_TEXT: begin
                    r_text <= r_text - 1'b1;
                    if (r_minus_pend) begin
                        r_minus_pend <= 1'b0;
                    end else begin
                        r_dptr <= r_dptr - 1'b1;
                    end
                end
                default: begin
                    r_lead <= 1'b0;
                end
            endcase
        end
        r_char <= sel_char;
        r_last <= i_cmd.last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= i_cmd.emit;
        end
    end

    always_comb begin
        o_status.is_dec    = (r_radix == RADIX_DEC);
        o_status.quot_zero = (quot == 32'd0);
        o_status.lead      = r_lead;
        o_status.pad_pre   = (r_pad != '0) && !r_left_justify;
        o_status.pad_post  = (r_pad != '0) && r_left_justify;
        o_status.pad_one   = (r_pad == CNT_W'(1));
        o_status.text_one  = (r_text == CNT_W'(1));
        // at load time the decision comes straight from the port
        if (i_cmd.load) begin
            o_status.is_dec = (i_radix_select == RADIX_DEC);
        end
    end

    assign o_char_strobe = r_strobe;
    assign o_out_char    = r_char;
    assign o_last_char   = r_last;

endmodule

>>> hw/rtl/integer_to_ascii_formatter_unit.sv
// Integer to ASCII formatter: radix 2/8/10/16, sign, width and padding.
// Each digit takes a divide step, in decimal a reciprocal multiply then a remainder step;
// a setup state and a lead state follow, then 1 character per cycle, each strobed in the
// cycle after it is chosen. A zero-padded '-' that leads goes out in the lead state.
// busy stays high until the last character is chosen, and the next start is taken
// only back in idle. Receiver cannot stall. Sync active-low reset idles.
module integer_to_ascii_formatter_unit import itoaf_pkg::*; #(
    parameter int MAX_WIDTH = ITOAF_MAX_WIDTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [31:0] i_value,
    input  logic [1:0]  i_radix_select,
    input  logic        i_is_signed,
    input  logic        i_is_long,
    input  logic [5:0]  i_field_width,
    input  logic        i_left_justify,
    input  logic        i_zero_fill,
    input  logic        i_upper_case,
    output logic        o_char_strobe,
    output logic [7:0]  o_out_char,
    output logic        o_last_char
);

    t_cmd    cmd;
    t_status status;

    itoaf_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_status (status),
        .o_cmd    (cmd)
    );

    itoaf_dp #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_value        (i_value),
        .i_radix_select (i_radix_select),
        .i_is_signed    (i_is_signed),
        .i_is_long      (i_is_long),
        .i_field_width  (i_field_width),
        .i_left_justify (i_left_justify),
        .i_zero_fill    (i_zero_fill),
        .i_upper_case   (i_upper_case),
        .i_cmd          (cmd),
        .o_status       (status),
        .o_char_strobe  (o_char_strobe),
        .o_out_char     (o_out_char),
        .o_last_char    (o_last_char)
    );

endmodule

>>> verif/tb_top.sv
// Self-checking testbench for integer_to_ascii_formatter_unit: directed and random numbers,
// predicted character strings compared one transfer at a time.
// Depends on itoaf_pkg and integer_to_ascii_formatter_unit.
`timescale 1ns / 100ps

module tb_top;
    import itoaf_pkg::*;

    typedef struct {
        logic [31:0] value;
        logic [1:0]  radix;
        logic        is_signed;
        logic        is_long;
        logic [5:0]  field_width;
        logic        left_justify;
        logic        zero_fill;
        logic        upper_case;
        int          gap_after;
        bit          drain_first;
    } fmt_req_t;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } fmt_char_t;

    logic        i_clk;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [31:0] i_value = '0;
    logic [1:0]  i_radix_select = RADIX_BIN;
    logic        i_is_signed = 1'b0;
    logic        i_is_long = 1'b0;
    logic [5:0]  i_field_width = '0;
    logic        i_left_justify = 1'b0;
    logic        i_zero_fill = 1'b0;
    logic        i_upper_case = 1'b0;
    logic        o_char_strobe;
    logic [7:0]  o_out_char;
    logic        o_last_char;

    fmt_req_t  pending_reqs[$];
    fmt_char_t expected_chars[$];
    fmt_req_t  cur_req;
    int        gap_cnt = 0;
    int        n_numbers = 0;
    int        n_chars = 0;
    int        n_negative = 0;
    int        n_truncated = 0;
    int        n_saturated = 0;
    int        n_errors = 0;

    integer_to_ascii_formatter_unit i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_value        (i_value),
        .i_radix_select (i_radix_select),
        .i_is_signed    (i_is_signed),
        .i_is_long      (i_is_long),
        .i_field_width  (i_field_width),
        .i_left_justify (i_left_justify),
        .i_zero_fill    (i_zero_fill),
        .i_upper_case   (i_upper_case),
        .o_char_strobe  (o_char_strobe),
        .o_out_char     (o_out_char),
        .o_last_char    (o_last_char)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Build the printed string for one number and queue its characters.
    function automatic void predict_chars(input fmt_req_t rq);
        logic [31:0] v;
        logic [31:0] mag;
        logic [31:0] rem;
        int unsigned base;
        int          w;
        int          len;
        int          pad_pre;
        int          pad_post;
        bit          neg;
        logic [7:0]  letter;
        logic [7:0]  padc;
        logic [7:0]  digs[$];
        logic [7:0]  txt[$];
        logic [7:0]  line[$];
        fmt_char_t   c;

        v = rq.value;
        if (!rq.is_long)
            v[31:16] = '0;
        if (int'(rq.field_width) > ITOAF_MAX_WIDTH) begin
            w = ITOAF_MAX_WIDTH;
            n_saturated++;
        end else begin
            w = int'(rq.field_width);
        end
        case (rq.radix)
            RADIX_BIN: base = 2;
            RADIX_OCT: base = 8;
            RADIX_DEC: base = 10;
            default:   base = 16;
        endcase

        mag = v;
        neg = 1'b0;
        if (rq.is_signed && rq.radix == RADIX_DEC && v != 0) begin
            if (rq.is_long && v[31]) begin
                neg = 1'b1;
                mag = 32'd0 - v;
            end else if (!rq.is_long && v[15]) begin
                neg = 1'b1;
                mag = 32'h0001_0000 - v;
            end
        end
        if (neg)
            n_negative++;

        letter = rq.upper_case ? CHAR_UPPER_A : CHAR_LOWER_A;
        if (mag == 0) begin
            digs.push_front(CHAR_ZERO);
        end else begin
            while (mag != 0) begin
                rem = mag % base;
                digs.push_front(rem >= 10 ? 8'(letter + rem - 10) : 8'(CHAR_ZERO + rem));
                mag = mag / base;
            end
        end

        // A zero-padded negative with a width sends its sign ahead of the field.
        if (neg && w > 0 && rq.zero_fill) begin
            line.push_back(CHAR_MINUS);
            w--;
        end else if (neg) begin
            txt.push_back(CHAR_MINUS);
        end
        foreach (digs[k])
            txt.push_back(digs[k]);

        len = txt.size();
        if (w > 0) begin
            if (len >= w) begin
                if (len > w)
                    n_truncated++;
                len = w;
                w = 0;
            end else begin
                w -= len;
            end
        end
        padc = rq.zero_fill ? CHAR_ZERO : CHAR_SPACE;
        pad_pre = rq.left_justify ? 0 : w;
        pad_post = rq.left_justify ? w : 0;
        for (int k = 0; k < pad_pre; k++)
            line.push_back(padc);
        for (int k = 0; k < len; k++)
            line.push_back(txt[k]);
        for (int k = 0; k < pad_post; k++)
            line.push_back(padc);

        foreach (line[k]) begin
            c.ch = line[k];
            c.last = (k == line.size() - 1);
            expected_chars.push_back(c);
        end
    endfunction

    function automatic fmt_req_t make_req(input logic [31:0] value, input logic [1:0] radix,
                                          input int sgn, input int lng,
                                          input int fw, input int lj,
                                          input int zf, input int uc);
        fmt_req_t rq;
        rq.value = value;
        rq.radix = radix;
        rq.is_signed = 1'(sgn);
        rq.is_long = 1'(lng);
        rq.field_width = 6'(fw);
        rq.left_justify = 1'(lj);
        rq.zero_fill = 1'(zf);
        rq.upper_case = 1'(uc);
        rq.gap_after = 0;
        rq.drain_first = 1'b0;
        return rq;
    endfunction

    // Driver: present one number per transfer, hold start until busy is low.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
            gap_cnt <= 0;
        end else begin
            if (start && !busy) begin
                predict_chars(cur_req);
                n_numbers++;
            end
            if (start && busy) begin
                // hold the pending transfer
            end else if (gap_cnt != 0) begin
                start <= 1'b0;
                gap_cnt <= gap_cnt - 1;
            end else if (pending_reqs.size() != 0 &&
                         (!pending_reqs[0].drain_first || expected_chars.size() == 0)) begin
                cur_req = pending_reqs.pop_front();
                i_value <= cur_req.value;
                i_radix_select <= cur_req.radix;
                i_is_signed <= cur_req.is_signed;
                i_is_long <= cur_req.is_long;
                i_field_width <= cur_req.field_width;
                i_left_justify <= cur_req.left_justify;
                i_zero_fill <= cur_req.zero_fill;
                i_upper_case <= cur_req.upper_case;
                start <= 1'b1;
                gap_cnt <= cur_req.gap_after;
            end else begin
                start <= 1'b0;
            end
        end
    end

    // Monitor: every strobe is one character transfer.
    always @(posedge i_clk) begin
        fmt_char_t want;
        if (i_rst_n && o_char_strobe) begin
            n_chars++;
            if (expected_chars.size() == 0) begin
                $error("unexpected character: out_char=%02h last_char=%0b",
                       o_out_char, o_last_char);
                n_errors++;
            end else begin
                want = expected_chars.pop_front();
                if (o_out_char !== want.ch) begin
                    $error("out_char: expected %02h, actual %02h", want.ch, o_out_char);
                    n_errors++;
                end
                if (o_last_char !== want.last) begin
                    $error("last_char: expected %0b, actual %0b", want.last, o_last_char);
                    n_errors++;
                end
            end
        end
    end

    initial begin
        fmt_req_t rq;
        int       sel;

        // Directed: extremes, every radix and the sign, width and padding corners.
        pending_reqs.push_back(make_req(32'h0000_0000, RADIX_DEC, 0, 1, 0, 0, 0, 0));
        pending_reqs.push_back(make_req(32'h0000_0000, RADIX_DEC, 1, 1, 5, 0, 1, 0));
        pending_reqs.push_back(make_req(32'hFFFF_FFFF, RADIX_BIN, 0, 1, 0, 0, 0, 0));
        pending_reqs.push_back(make_req(32'hFFFF_FFFF, RADIX_OCT, 0, 1, 0, 0, 0, 0));
        pending_reqs.push_back(make_req(32'hFFFF_FFFF, RADIX_DEC, 0, 1, 0, 0, 0, 0));
        pending_reqs.push_back(make_req(32'hFFFF_FFFF, RADIX_HEX, 0, 1, 0, 0, 0, 1));
        pending_reqs.push_back(make_req(32'hDEAD_BEEF, RADIX_HEX, 0, 1, 0, 0, 0, 0));
        pending_reqs.push_back(make_req(32'h8000_0000, RADIX_DEC, 1, 1, 0, 0, 0, 0));
        pending_reqs.push_back(make_req(32'h0001_8000, RADIX_DEC, 1, 0, 0, 0, 0, 0));
        pending_reqs.push_back(make_req(32'hABCD_7FFF, RADIX_DEC, 1, 0, 0, 0, 0, 0));
        pending_reqs.push_back(make_req(32'h8000_0000, RADIX_HEX, 1, 1, 0, 0, 0, 0));
        pending_reqs.push_back(make_req(32'h8000_0001, RADIX_BIN, 1, 1, 0, 0, 0, 0));
        pending_reqs.push_back(make_req(32'hFFFF_FFF9, RADIX_DEC, 1, 1, 1, 0, 1, 0));
        pending_reqs.push_back(make_req(32'hFFFF_FFF9, RADIX_DEC, 1, 1, 4, 0, 1, 0));
        pending_reqs.push_back(make_req(32'hFFFF_FFF9, RADIX_DEC, 1, 1, 4, 0, 0, 0));
        pending_reqs.push_back(make_req(32'hFFFF_FFF9, RADIX_DEC, 1, 1, 4, 1, 1, 0));
        pending_reqs.push_back(make_req(32'd12345,     RADIX_DEC, 1, 1, 3, 0, 0, 0));
        pending_reqs.push_back(make_req(32'hFFFF_8765, RADIX_DEC, 1, 1, 2, 0, 0, 0));
        pending_reqs.push_back(make_req(32'hFFFF_FF85, RADIX_DEC, 1, 1, 1, 0, 0, 0));
        pending_reqs.push_back(make_req(32'd42,        RADIX_DEC, 0, 1, 6, 1, 0, 0));
        pending_reqs.push_back(make_req(32'd42,        RADIX_DEC, 0, 1, 6, 1, 1, 0));
        pending_reqs.push_back(make_req(32'd5,         RADIX_BIN, 0, 1, 63, 0, 0, 0));
        pending_reqs.push_back(make_req(32'hFFFF_FFFF, RADIX_BIN, 0, 1, 32, 0, 1, 0));
        pending_reqs.push_back(make_req(32'hFFFF_FFFF, RADIX_BIN, 0, 0, 0, 0, 0, 0));
        rq = make_req(32'h5A5A_1234, RADIX_HEX, 0, 0, 33, 0, 1, 1);
        rq.drain_first = 1'b1;
        pending_reqs.push_back(rq);

        // Random: mixed value classes; alternate bursts with and without gaps.
        for (int n = 0; n < 285; n++) begin
            sel = $urandom_range(0, 9);
            case (sel)
                0, 1, 2: rq.value = $urandom;
                3, 4:    rq.value = $urandom_range(0, 20);
                5:       rq.value = {16'($urandom_range(0, 16'hFFFF)), 16'h8000} +
                                    $urandom_range(0, 4) - 2;
                6:       rq.value = 32'h8000_0000 + $urandom_range(0, 4) - 2;
                7:       rq.value = 32'hFFFF_FFFF - $urandom_range(0, 200);
                8:       rq.value = $urandom_range(0, 16'hFFFF);
                default: rq.value = 32'd1 << $urandom_range(0, 31);
            endcase
            rq.radix = 2'($urandom_range(0, 3));
            if ($urandom_range(0, 2) == 0)
                rq.radix = RADIX_DEC;
            rq.is_signed = 1'($urandom_range(0, 1));
            rq.is_long = 1'($urandom_range(0, 1));
            sel = $urandom_range(0, 9);
            if (sel < 5)
                rq.field_width = '0;
            else if (sel < 8)
                rq.field_width = 6'($urandom_range(1, 12));
            else if (sel == 8)
                rq.field_width = 6'($urandom_range(13, 32));
            else
                rq.field_width = 6'($urandom_range(33, 63));
            rq.left_justify = 1'($urandom_range(0, 1));
            rq.zero_fill = 1'($urandom_range(0, 1));
            rq.upper_case = 1'($urandom_range(0, 1));
            if ((n / 25) % 3 == 2) begin
                rq.gap_after = 0;
            end else begin
                sel = $urandom_range(0, 9);
                if (sel < 6)
                    rq.gap_after = 0;
                else if (sel < 9)
                    rq.gap_after = $urandom_range(1, 3);
                else
                    rq.gap_after = $urandom_range(10, 60);
            end
            rq.drain_first = (n % 70 == 35);
            pending_reqs.push_back(rq);
        end

        i_rst_n = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Wait for every transfer to be taken and every character to arrive.
        while (pending_reqs.size() != 0 || start || expected_chars.size() != 0)
            @(posedge i_clk);
        repeat (120) @(posedge i_clk);

        $display("Formatted %0d numbers into %0d characters: %0d negative, %0d truncated,",
                 n_numbers, n_chars, n_negative, n_truncated);
        $display("%0d with saturated width, %0d errors.", n_saturated, n_errors);
        if (n_errors == 0 && expected_chars.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("Timeout with %0d characters still expected", expected_chars.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
